// ===== hdl/lc3_subset_instruction_step_top_macros.svh =====
// assertion macros for the lc3 subset step core
// expects clk and rst in the scope of each use
`ifndef LC3_SUBSET_INSTRUCTION_STEP_TOP_MACROS_SVH
`define LC3_SUBSET_INSTRUCTION_STEP_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LC3S_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LC3S_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lc3s_pkg.sv =====
// shared types and constants for the lc3 subset step core
// no dependencies
package lc3s_pkg;

  // request transaction payload
  typedef struct packed {
    logic        operation;
    logic [4:0]  address;
    logic [15:0] data;
  } req_t;

  // response transaction payload
  typedef struct packed {
    logic        halted;
    logic [15:0] pc;
    logic [15:0] ir;
    logic [2:0]  cond_flags;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [4:0]  mem_address;
    logic [15:0] mem_value;
  } rsp_t;

  // request operation codes
  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_STEP = 1'b1;

  // instruction opcodes
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [7:0] HALT_VECTOR = 8'h19;

  // condition codes: n bit 2, z bit 1, p bit 0
  localparam logic [2:0] CC_N = 3'b100;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_P = 3'b001;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v[15]) f = CC_N;
    else if (v == 16'd0) f = CC_Z;
    else f = CC_P;
    return f;
  endfunction

endpackage

// ===== hdl/lc3_subset_instruction_step_top.sv =====
// A load, or a step while halted, goes straight to the done state. A step reduces the pc, reads,
// decodes and executes; ld and st then reduce their address and access memory. Each memory
// address (fetch, ld, st) is reduced modulo MEM_WORDS by two passes through the one shared
// multiplier and a subtract; fetch and ld add one registered memory read. A new request waits
// until the result leaves the done state. Reset: synchronous; a clearing pass then zeroes memory,
// no transaction accepted meanwhile. Registers reset to their own index via per-entry valid bits.
// lc3 subset core top level: program memory, register file, sequencer and shared multiplier
// depends on lc3s_pkg and lc3_subset_instruction_step_top_macros.svh
`include "lc3_subset_instruction_step_top_macros.svh"

module lc3_subset_instruction_step_top #(
  parameter int MEM_WORDS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lc3s_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lc3s_pkg::rsp_t  rsp
);
  import lc3s_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam longint unsigned RECIP = (64'd4294967296 + MEM_WORDS - 1) / MEM_WORDS;
  localparam int RW = $clog2(RECIP + 1);
  localparam int PW = 16 + RW;
  localparam logic [RW-1:0] RECIP_B = RW'(RECIP);
  localparam logic [RW-1:0] MOD_B   = RW'(MEM_WORDS);
  localparam logic [16:0]   MOD_17  = 17'(MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULQ = 4'd1;
  localparam logic [3:0] S_MULB = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_DEC  = 4'd5;
  localparam logic [3:0] S_EXA  = 4'd6;
  localparam logic [3:0] S_EXB  = 4'd7;
  localparam logic [3:0] S_LDW  = 4'd8;
  localparam logic [3:0] S_STW  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // control state
  logic [3:0]    state;
  logic [15:0]   pc;
  logic [2:0]    cc;
  logic          halt;
  logic          clearing;
  logic [AW-1:0] clr_cnt;
  logic          phase_data;
  logic [7:0]    rf_valid;

  // datapath registers
  logic [15:0]   ir;
  logic [15:0]   opnd_a;
  logic [15:0]   opnd_b;
  logic [15:0]   mod_in;
  logic [PW-1:0] prod;
  logic [AW-1:0] addr_q;
  rsp_t          res;

  // memories
  logic [15:0]   mem [MEM_WORDS];
  logic [15:0]   mem_rdata;
  logic [15:0]   rf_mem [8];
  logic [15:0]   rf_rdata;
  logic          rf_rvalid;
  logic [2:0]    rf_raddr_q;

  // combinational signals
  logic          accept;
  logic          done_fire;
  logic [3:0]    opcode;
  logic [2:0]    dr;
  logic [15:0]   sext5;
  logic [15:0]   off9;
  logic [15:0]   rf_q;
  logic [15:0]   alu_b;
  logic [15:0]   alu_res;
  logic          is_alu;
  logic          ben;
  logic [15:0]   mul_a;
  logic [RW-1:0] mul_b;
  logic [16:0]   diff;
  logic [16:0]   corr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          rf_re;
  logic [2:0]    rf_raddr;
  logic          rf_we;
  logic [15:0]   rf_wdata;
  rsp_t          res_next;
  rsp_t          rsp_next;

  assign req_stall = clearing || (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign done_fire = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // instruction fields
  assign opcode = ir[15:12];
  assign dr     = ir[11:9];
  assign sext5  = {{11{ir[4]}}, ir[4:0]};
  assign off9   = {{7{ir[8]}}, ir[8:0]};
  assign ben    = |(ir[11:9] & cc);
  assign is_alu = (opcode == OP_ADD) || (opcode == OP_AND) || (opcode == OP_NOT);

  // register read result, never-written entries read as their index
  assign rf_q = rf_rvalid ? rf_rdata : {13'd0, rf_raddr_q};

  // alu
  assign alu_b = ir[5] ? sext5 : rf_q;
  always_comb begin
    unique case (opcode)
      OP_ADD:  alu_res = opnd_a + alu_b;
      OP_AND:  alu_res = opnd_a & alu_b;
      default: alu_res = ~opnd_a;
    endcase
  end

  // shared multiplier operands: reciprocal pass, then quotient times modulus
  assign mul_a = (state == S_MULB) ? 16'(prod[PW-1:32]) : mod_in;
  assign mul_b = (state == S_MULB) ? MOD_B : RECIP_B;

  // remainder with one correction step
  assign diff = {1'b0, mod_in} - prod[16:0];
  assign corr = (diff >= MOD_17) ? diff - MOD_17 : diff;

  // result started at acceptance: a load reports its write, a step starts empty
  always_comb begin
    res_next = '0;
    if (accept && req.operation == OPER_LOAD) begin
      res_next.mem_written = 1'b1;
      res_next.mem_address = req.address;
      res_next.mem_value   = req.data;
    end
  end

  // outgoing result with the architectural state after the transaction
  always_comb begin
    rsp_next            = res;
    rsp_next.halted     = halt;
    rsp_next.pc         = pc;
    rsp_next.cond_flags = cc;
  end

  // program memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
    end else if (accept && req.operation == OPER_LOAD) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(req.address);
      mem_wdata = req.data;
    end else if (state == S_STW) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = opnd_b;
    end
  end

  // register file ports
  always_comb begin
    rf_re    = 1'b0;
    rf_raddr = '0;
    if (state == S_DEC) begin
      rf_re    = 1'b1;
      rf_raddr = mem_rdata[8:6];
    end else if (state == S_EXA) begin
      rf_re    = 1'b1;
      rf_raddr = (opcode == OP_ST) ? ir[11:9] : ir[2:0];
    end
  end
  assign rf_we    = (state == S_LDW) || (state == S_EXB && is_alu);
  assign rf_wdata = (state == S_LDW) ? mem_rdata : alu_res;

  // program memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state == S_RD) mem_rdata <= mem[addr_q];
  end

  // register file storage
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[dr] <= rf_wdata;
    if (rf_re) begin
      rf_rdata   <= rf_mem[rf_raddr];
      rf_rvalid  <= rf_valid[rf_raddr];
      rf_raddr_q <= rf_raddr;
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      pc         <= '0;
      cc         <= '0;
      halt       <= 1'b0;
      clearing   <= 1'b1;
      clr_cnt    <= '0;
      phase_data <= 1'b0;
      rf_valid   <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == LAST_ADDR) clearing <= 1'b0;
      end
      if (done_fire) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (rf_we) begin
        rf_valid[dr] <= 1'b1;
        cc           <= flags_of(rf_wdata);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.operation == OPER_LOAD || halt) begin
              state <= S_DONE;
            end else begin
              phase_data <= 1'b0;
              state      <= S_MULQ;
            end
          end
        end
        S_MULQ: state <= S_MULB;
        S_MULB: state <= S_SUB;
        S_SUB:  state <= (phase_data && opcode == OP_ST) ? S_STW : S_RD;
        S_RD:   state <= phase_data ? S_LDW : S_DEC;
        S_DEC: begin
          pc    <= pc + 16'd1;
          state <= S_EXA;
        end
        S_EXA: begin
          unique case (opcode) inside
            OP_JMP: begin
              pc    <= rf_q;
              state <= S_DONE;
            end
            OP_BR: begin
              if (ben) pc <= pc + off9;
              state <= S_DONE;
            end
            OP_TRAP: begin
              if (ir[7:0] == HALT_VECTOR) halt <= 1'b1;
              state <= S_DONE;
            end
            OP_ADD, OP_AND, OP_NOT, OP_LD, OP_ST: state <= S_EXB;
            default: state <= S_DONE;
          endcase
        end
        S_EXB: begin
          if (opcode == OP_LD || opcode == OP_ST) begin
            phase_data <= 1'b1;
            state      <= S_MULQ;
          end else begin
            state <= S_DONE;
          end
        end
        S_LDW:  state <= S_DONE;
        S_STW:  state <= S_DONE;
        S_DONE: begin
          if (done_fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath and result assembly
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mod_in <= pc;
        res    <= res_next;
      end
      S_MULQ, S_MULB: prod <= PW'(mul_a) * PW'(mul_b);
      S_SUB:  addr_q <= corr[AW-1:0];
      S_DEC: begin
        ir     <= mem_rdata;
        res.ir <= mem_rdata;
      end
      S_EXA:  opnd_a <= rf_q;
      S_EXB: begin
        opnd_b <= rf_q;
        mod_in <= pc + off9;
        if (is_alu) begin
          res.reg_written <= 1'b1;
          res.reg_index   <= dr;
          res.reg_value   <= alu_res;
        end
      end
      S_LDW: begin
        res.reg_written <= 1'b1;
        res.reg_index   <= dr;
        res.reg_value   <= mem_rdata;
      end
      S_STW: begin
        res.mem_written <= 1'b1;
        res.mem_address <= addr_q[4:0];
        res.mem_value   <= opnd_b;
      end
      S_DONE: begin
        if (done_fire) rsp <= rsp_next;
      end
      default: ;
    endcase
  end

  // checks
  `LC3S_ASSERT_NXT(a_halt_sticky, halt, halt, "halt flag dropped without reset")
  `LC3S_ASSERT_NXT(a_accept_busy, accept, state != S_IDLE, "accepted transaction not started")
  `LC3S_ASSERT_NXT(a_done_hold, state == S_DONE && rsp_valid && rsp_stall, state == S_DONE && rsp_valid, "finished result lost while response stalled")
  `LC3S_ASSERT_IMP(a_one_write, rsp_valid, !(rsp.reg_written && rsp.mem_written), "response reports both register and memory write")

endmodule
